/* hw/rtl/msp_pkg.sv */
`default_nettype none

package msp_pkg;

  // pool and stack sizing
  localparam int NUM_STACKS = 4;
  localparam int POOL_SIZE  = 16;

  // field widths
  localparam int OP_W     = 1;
  localparam int SID_W    = 2;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;

  // slot index and pointer (pointer adds the null code POOL_SIZE)
  localparam int IDX_W = $clog2(POOL_SIZE);
  localparam int PTR_W = $clog2(POOL_SIZE + 1);

  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(POOL_SIZE);

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH = 1'b0;
  localparam logic [OP_W-1:0] OP_POP  = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // write port of the link store
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [PTR_W-1:0] data;
  } link_wr_t;

endpackage

`default_nettype wire

/* hw/rtl/multi_stack_shared_pool_core.sv */
// latency: a command accepted at one edge is executed in the next cycle and its
//   result beat (done high for one cycle) appears in the cycle after that
// busy refuses a new command until the previous one is through: the synchronous read of the
//   link and value memories is followed by the write-back of the same entry
// reset: rst (synchronous) empties all stacks and threads every slot onto the free list
// the receiver cannot stall: each result beat is taken in the cycle it is shown
`default_nettype none

module multi_stack_shared_pool_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [msp_pkg::OP_W-1:0]            op,
  input  wire logic [msp_pkg::SID_W-1:0]           stack_id,
  input  wire logic signed [msp_pkg::VAL_W-1:0]    push_value,
  output logic                                     done,
  output logic      [msp_pkg::STATUS_W-1:0]        status,
  output logic signed [msp_pkg::VAL_W-1:0]         pop_value
);

  // two-state sequencer: idle accepts a command, exec does the write-back
  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;

  // stack tops and free-list head live in flops
  logic [msp_pkg::PTR_W-1:0] tops [msp_pkg::NUM_STACKS];
  logic [msp_pkg::PTR_W-1:0] free_head;

  // command captured at accept
  logic [msp_pkg::OP_W-1:0]  op_q;
  logic [msp_pkg::SID_W-1:0] sid_q;
  logic [msp_pkg::VAL_W-1:0] val_q;
  logic [msp_pkg::PTR_W-1:0] slot_q;
  logic                      fail_q;

  logic                      accept;
  logic                      sid_bad;
  logic [msp_pkg::PTR_W-1:0] top_sel;
  logic [msp_pkg::PTR_W-1:0] slot_sel;
  logic                      fail_sel;

  // memory ports
  msp_pkg::link_wr_t         link_wr;
  logic [msp_pkg::PTR_W-1:0] link_rdata;
  logic                      val_we;
  logic [msp_pkg::VAL_W-1:0] val_rdata;

  assign busy   = (state == S_EXEC);
  assign accept = start && !busy;

  // stack numbers past the last stack behave as a stack with no slots
  assign sid_bad = (int'(stack_id) >= msp_pkg::NUM_STACKS);
  assign top_sel = sid_bad ? msp_pkg::NULL_PTR : tops[stack_id];

  // push works on the free-list head, pop on the stack top
  always_comb begin
    if (op == msp_pkg::OP_PUSH) begin
      slot_sel = free_head;
      fail_sel = sid_bad || (free_head >= msp_pkg::NULL_PTR);
    end else begin
      slot_sel = top_sel;
      fail_sel = (top_sel >= msp_pkg::NULL_PTR);
    end
  end

  always_comb begin
    case (state)
      S_IDLE: state_next = accept ? S_EXEC : S_IDLE;
      S_EXEC: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // capture the command; the memories are read at the same edge
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= op;
      sid_q  <= stack_id;
      val_q  <= push_value;
      slot_q <= slot_sel;
      fail_q <= fail_sel;
    end
  end

  // write-back in the exec cycle; the busy interlock keeps the next read
  // behind this write, so no forwarding is needed
  always_comb begin
    link_wr.en   = busy && !fail_q;
    link_wr.addr = slot_q[msp_pkg::IDX_W-1:0];
    if (op_q == msp_pkg::OP_PUSH) begin
      link_wr.data = tops[sid_q];   // new slot points at old top
    end else begin
      link_wr.data = free_head;     // freed slot points at old free head
    end
  end

  assign val_we = busy && !fail_q && (op_q == msp_pkg::OP_PUSH);

  msp_link_store u_links (
    .clk   (clk),
    .rst   (rst),
    .wr    (link_wr),
    .re    (accept),
    .raddr (slot_sel[msp_pkg::IDX_W-1:0]),
    .rdata (link_rdata)
  );

  msp_ram #(
    .WIDTH (msp_pkg::VAL_W),
    .DEPTH (msp_pkg::POOL_SIZE)
  ) u_values (
    .clk   (clk),
    .we    (val_we),
    .waddr (slot_q[msp_pkg::IDX_W-1:0]),
    .wdata (val_q),
    .re    (accept),
    .raddr (slot_sel[msp_pkg::IDX_W-1:0]),
    .rdata (val_rdata)
  );

  // tops and free head
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < msp_pkg::NUM_STACKS; i++) begin
        tops[i] <= msp_pkg::NULL_PTR;
      end
      free_head <= '0;
    end else if (busy && !fail_q) begin
      if (op_q == msp_pkg::OP_PUSH) begin
        free_head   <= link_rdata;
        tops[sid_q] <= slot_q;
      end else begin
        free_head   <= slot_q;
        tops[sid_q] <= link_rdata;
      end
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      if (fail_q) begin
        status    <= (op_q == msp_pkg::OP_PUSH) ? msp_pkg::ST_FULL : msp_pkg::ST_EMPTY;
        pop_value <= '0;
      end else if (op_q == msp_pkg::OP_PUSH) begin
        status    <= msp_pkg::ST_OK;
        pop_value <= '0;
      end else begin
        status    <= msp_pkg::ST_OK;
        pop_value <= val_rdata;
      end
    end
  end

  // every accepted command gives exactly one exec cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted command did not enter exec");

  a_exec_single: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy && done)
    else $error("exec cycle not followed by a result beat");

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without a preceding exec cycle");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status != msp_pkg::ST_OK) |-> (pop_value == '0))
    else $error("failed command returned a nonzero value");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == msp_pkg::ST_OK) || (status == msp_pkg::ST_FULL) ||
             (status == msp_pkg::ST_EMPTY))
    else $error("result beat carries an undefined status");

endmodule

`default_nettype wire

/* hw/rtl/msp_ram.sv */
`default_nettype none

module msp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/msp_link_store.sv */
`default_nettype none

module msp_link_store (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire msp_pkg::link_wr_t           wr,
  input  wire logic                        re,
  input  wire logic [msp_pkg::IDX_W-1:0]   raddr,
  output logic      [msp_pkg::PTR_W-1:0]   rdata
);

  logic [msp_pkg::PTR_W-1:0]     mem [msp_pkg::POOL_SIZE];
  logic [msp_pkg::POOL_SIZE-1:0] valid;
  logic [msp_pkg::PTR_W-1:0]     init_link;

  // untouched slot links to the next one, the last one to null
  assign init_link = msp_pkg::PTR_W'(raddr) + msp_pkg::PTR_W'(1);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= valid[raddr] ? mem[raddr] : init_link;
    end
  end

endmodule

`default_nettype wire
